// ===== design/integer_stack_machine_top_macros.svh =====
// Assertion shorthands for the stack machine; clock clk, reset arst_n.
`ifndef INTEGER_STACK_MACHINE_TOP_MACROS_SVH
`define INTEGER_STACK_MACHINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ism_pkg.sv =====
`default_nettype none

package ism_pkg;

	// Word and iteration widths of the datapath.
	localparam int WORD_W = 64;
	localparam int CNT_W  = 6;

	// Instruction codes; codes above ACT_SWAP do nothing.
	typedef logic [3:0] action_t;
	localparam action_t ACT_CONST = 4'd0;
	localparam action_t ACT_ADD   = 4'd1;
	localparam action_t ACT_SUB   = 4'd2;
	localparam action_t ACT_MUL   = 4'd3;
	localparam action_t ACT_DIV   = 4'd4;
	localparam action_t ACT_MAX   = 4'd5;
	localparam action_t ACT_MIN   = 4'd6;
	localparam action_t ACT_NEG   = 4'd7;
	localparam action_t ACT_DUP   = 4'd8;
	localparam action_t ACT_SWAP  = 4'd9;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_READ = 8'b0000_0010,
		S_NEG  = 8'b0000_0100,
		S_ABSA = 8'b0000_1000,
		S_ABSB = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_FIX  = 8'b0100_0000,
		S_MUL  = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// ===== design/ism_ram.sv =====
`default_nettype none

module ism_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/integer_stack_machine_top.sv =====
// Const, dup, underflow, overflow and unknown actions finish straight from the idle state;
// neg passes through S_NEG; add, sub, max, min, swap and divide by zero pass through S_READ;
// mul adds S_MUL, and div adds S_ABSA, S_ABSB, S_DIV and S_FIX. Multiply and divide run one
// bit per cycle through the single shared 64-bit adder; no new instruction is taken until idle.
// busy stays high until the result is ready; the receiver cannot stall the strobe.
// Reset (arst_n low, asynchronous) empties the stack; stored words are not cleared.
`default_nettype none

`include "integer_stack_machine_top_macros.svh"

module integer_stack_machine_top #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire ism_pkg::action_t    action,
	input  wire logic signed [31:0]  value,
	output logic                     done,
	output logic signed [63:0]       top_value,
	output logic        [6:0]        depth,
	output ism_pkg::status_t         status
);

	import ism_pkg::*;

	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(STACK_DEPTH);
	localparam logic [LVL_W-1:0] ONE_LVL  = LVL_W'(1);
	localparam logic [LVL_W-1:0] TWO_LVL  = LVL_W'(2);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_W - 1);

	// Control registers.
	state_t           state_q, state_d;
	logic [LVL_W-1:0] level_q, level_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q, done_d;
	status_t          status_q, status_d;

	// Datapath registers; the top element lives in top_q, the rest in the RAM.
	logic [WORD_W-1:0] top_q, top_d;
	logic [WORD_W-1:0] a_q, a_d;
	logic [WORD_W-1:0] b_q, b_d;
	logic [WORD_W-1:0] acc_q, acc_d;
	logic              neg_q, neg_d;
	action_t           act_q, act_d;

	// Stack memory port signals.
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, top_addr, sec_addr;
	logic [WORD_W-1:0] rd_data;

	// Shared adder/subtractor.
	logic [WORD_W-1:0] op_a, op_b;
	logic              op_sub;
	logic [WORD_W:0]   sum;
	logic              carry;
	logic              a_less;
	logic [WORD_W-1:0] partial;

	logic accept;

	assign accept   = start && (state_q == S_IDLE);
	assign top_addr = ADDR_W'(level_q - ONE_LVL);
	assign sec_addr = ADDR_W'(level_q - TWO_LVL);
	assign partial  = {acc_q[WORD_W-2:0], a_q[WORD_W-1]};

	ism_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (top_q),
		.rd_en   (ram_re),
		.rd_addr (sec_addr),
		.rd_data (rd_data)
	);

	// Operand selection for the shared adder.
	always_comb begin
		op_a   = '0;
		op_b   = top_q;
		op_sub = 1'b1;
		case (state_q)
			S_READ: begin
				op_a   = top_q;
				op_b   = rd_data;
				op_sub = (act_q != ACT_ADD);
			end
			S_NEG: begin
				op_b = top_q;
			end
			S_ABSA, S_FIX: begin
				op_b = a_q;
			end
			S_ABSB: begin
				op_b = b_q;
			end
			S_DIV: begin
				op_a = partial;
				op_b = b_q;
			end
			S_MUL: begin
				op_a   = acc_q;
				op_b   = b_q[0] ? a_q : '0;
				op_sub = 1'b0;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum    = {1'b0, op_a} + {1'b0, op_b ^ {WORD_W{op_sub}}} + (WORD_W + 1)'(op_sub);
	assign carry  = sum[WORD_W];
	assign a_less = (top_q[WORD_W-1] != rd_data[WORD_W-1]) ? top_q[WORD_W-1]
		: sum[WORD_W-1];

	// RAM access: pushes spill the old top, binary operations fetch the second element, and swap writes the old top there.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = top_addr;
		if (accept) begin
			case (action)
				ACT_CONST, ACT_DUP: begin
					ram_we = (level_q != '0) && (level_q < FULL_LVL);
				end
				ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MAX, ACT_MIN, ACT_SWAP: begin
					ram_re = (level_q >= TWO_LVL);
				end
				default: begin
					ram_re = 1'b0;
				end
			endcase
		end else if ((state_q == S_READ) && (act_q == ACT_SWAP)) begin
			ram_we    = 1'b1;
			ram_waddr = sec_addr;
		end
	end

	// Sequencer and next-state datapath.
	always_comb begin
		state_d  = state_q;
		level_d  = level_q;
		cnt_d    = cnt_q;
		done_d   = 1'b0;
		status_d = status_q;
		top_d    = top_q;
		a_d      = a_q;
		b_d      = b_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		act_d    = act_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					act_d    = action;
					status_d = ST_OK;
					done_d   = 1'b1;
					case (action)
						ACT_CONST: begin
							if (level_q >= FULL_LVL) begin
								status_d = ST_OVER;
							end else begin
								top_d   = {{(WORD_W - 32){value[31]}}, value};
								level_d = level_q + ONE_LVL;
							end
						end
						ACT_DUP: begin
							if (level_q == '0) begin
								status_d = ST_UNDER;
							end else if (level_q >= FULL_LVL) begin
								status_d = ST_OVER;
							end else begin
								level_d = level_q + ONE_LVL;
							end
						end
						ACT_NEG: begin
							if (level_q == '0) begin
								status_d = ST_UNDER;
							end else begin
								done_d  = 1'b0;
								state_d = S_NEG;
							end
						end
						ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MAX, ACT_MIN, ACT_SWAP: begin
							if (level_q < TWO_LVL) begin
								status_d = ST_UNDER;
							end else begin
								done_d  = 1'b0;
								state_d = S_READ;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (act_q)
					ACT_ADD, ACT_SUB: begin
						top_d   = sum[WORD_W-1:0];
						level_d = level_q - ONE_LVL;
					end
					ACT_MAX: begin
						top_d   = a_less ? rd_data : top_q;
						level_d = level_q - ONE_LVL;
					end
					ACT_MIN: begin
						top_d   = a_less ? top_q : rd_data;
						level_d = level_q - ONE_LVL;
					end
					ACT_SWAP: begin
						top_d = rd_data;
					end
					ACT_MUL: begin
						a_d     = top_q;
						b_d     = rd_data;
						acc_d   = '0;
						done_d  = 1'b0;
						state_d = S_MUL;
					end
					ACT_DIV: begin
						if (rd_data == '0) begin
							status_d = ST_DIVZ;
						end else begin
							a_d     = top_q;
							b_d     = rd_data;
							neg_d   = top_q[WORD_W-1] ^ rd_data[WORD_W-1];
							done_d  = 1'b0;
							state_d = S_ABSA;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_NEG: begin
				top_d   = sum[WORD_W-1:0];
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_ABSA: begin
				if (a_q[WORD_W-1]) begin
					a_d = sum[WORD_W-1:0];
				end
				state_d = S_ABSB;
			end
			S_ABSB: begin
				if (b_q[WORD_W-1]) begin
					b_d = sum[WORD_W-1:0];
				end
				acc_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				// Restoring division: one quotient bit per cycle.
				acc_d = carry ? sum[WORD_W-1:0] : partial;
				a_d   = {a_q[WORD_W-2:0], carry};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				top_d   = neg_q ? sum[WORD_W-1:0] : a_q;
				level_d = level_q - ONE_LVL;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_MUL: begin
				// Shift-and-add multiply keeping the low word.
				acc_d = sum[WORD_W-1:0];
				a_d   = {a_q[WORD_W-2:0], 1'b0};
				b_d   = {1'b0, b_q[WORD_W-1:1]};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					top_d   = sum[WORD_W-1:0];
					level_d = level_q - ONE_LVL;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			level_q  <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			level_q  <= level_d;
			cnt_q    <= cnt_d;
			done_q   <= done_d;
			status_q <= status_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		top_q <= top_d;
		a_q   <= a_d;
		b_q   <= b_d;
		acc_q <= acc_d;
		neg_q <= neg_d;
		act_q <= act_d;
	end

	// Result ports show the state after the finished transaction.
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign top_value = (level_q != '0) ? top_q : '0;
	assign depth     = 7'(level_q);
	assign status    = status_q;

	// The stack count never passes its capacity.
	`ISM_ASSERT_NOW(a_level_bound, 1'b1, level_q <= FULL_LVL, "stack level above capacity")
	// A result is only reported once the sequencer is back at rest.
	`ISM_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")
	// The stack count only moves together with a result.
	`ISM_ASSERT_NEXT(a_level_with_done, level_d != level_q, done_q, "level changed silently")
	// The bit counter is at zero whenever no iteration runs.
	`ISM_ASSERT_NOW(a_cnt_rest, (state_q != S_DIV) && (state_q != S_MUL), cnt_q == '0,
		"iteration counter not at rest")

endmodule

`default_nettype wire
